[hdl/lpfr_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lpfr_pkg
// shared types and constants of the length-prefixed frame receiver
// ---------------------------------------------------------------------------
package lpfr_pkg;

    localparam int unsigned HDR_BYTES    = 12;
    localparam int unsigned HDR_IDX_W    = 4;
    localparam int unsigned CFG_ADDR_W   = 8;
    localparam int unsigned CFG_DATA_W   = 16;
    localparam int unsigned BODY_LEN_W   = 13;

    localparam logic [HDR_IDX_W-1:0] HDR_LAST = 4'd11;

    localparam logic [15:0] MAGIC_RESET    = 16'hBEEF;
    localparam logic [BODY_LEN_W-1:0] MAX_LEN_RESET = 13'd1024;

    localparam logic [CFG_ADDR_W-1:0] CFG_MAGIC_WORD   = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_BODY_LEN = 8'd1;

    localparam logic [15:0] CMD_PING = 16'd1;
    localparam logic [15:0] CMD_TEXT = 16'd3;
    localparam logic [15:0] CMD_BYE  = 16'd5;

    localparam logic [1:0] KIND_BODY      = 2'd0;
    localparam logic [1:0] KIND_DONE      = 2'd1;
    localparam logic [1:0] KIND_BAD_MAGIC = 2'd2;
    localparam logic [1:0] KIND_TOO_LONG  = 2'd3;

    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_PONG  = 2'd1;
    localparam logic [1:0] ACT_ACK   = 2'd2;
    localparam logic [1:0] ACT_CLOSE = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic        has_data;
        logic [15:0] command;
        logic [15:0] frame_seq;
        logic [31:0] body_length;
        logic [1:0]  action;
        logic [15:0] reply_seq;
    } t_result;

endpackage

[hdl/lpfr_in_reg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lpfr_in_reg
// input register holding one received byte until the parser takes it
// ---------------------------------------------------------------------------
module lpfr_in_reg import lpfr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data,
    output logic       o_valid,
    output logic [7:0] o_data,
    input  logic       i_take
);

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_data;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_valid = r_valid;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_valid && o_ready) begin
            r_data <= i_data;
        end
    end

endmodule

[hdl/lpfr_parser.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lpfr_parser
// header assembly, checks, body pass-through and reply decision
// ---------------------------------------------------------------------------
module lpfr_parser import lpfr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_fire,
    input  logic [7:0]            i_byte,
    output logic                  o_res_valid,
    output t_result               o_res
);

    logic [15:0]           r_magic_word;
    logic [BODY_LEN_W-1:0] r_max_body_len;

    logic [HDR_IDX_W-1:0]  r_hdr_idx,   n_hdr_idx;
    logic                  r_in_body,   n_in_body;
    logic [15:0]           r_magic_acc, n_magic_acc;
    logic [15:0]           r_command,   n_command;
    logic [15:0]           r_seq,       n_seq;
    logic [31:0]           r_length,    n_length;
    logic [BODY_LEN_W-1:0] r_left,      n_left;
    logic [15:0]           r_reply_cnt, n_reply_cnt;
    logic                  r_closed,    n_closed;

    logic [1:0]            dec_action;
    logic [15:0]           dec_cnt;
    logic                  dec_close;

    // reply decision at frame completion
    always_comb begin
        dec_action = ACT_NONE;
        dec_cnt    = r_reply_cnt;
        dec_close  = 1'b0;
        if (r_command == CMD_PING) begin
            dec_action = ACT_PONG;
            dec_cnt    = r_reply_cnt + 16'd1;
        end else if (r_command == CMD_TEXT) begin
            dec_action = ACT_ACK;
            dec_cnt    = r_reply_cnt + 16'd1;
        end else if (r_command == CMD_BYE) begin
            dec_action = ACT_CLOSE;
            dec_close  = 1'b1;
        end
    end

    always_comb begin
        n_hdr_idx   = r_hdr_idx;
        n_in_body   = r_in_body;
        n_magic_acc = r_magic_acc;
        n_command   = r_command;
        n_seq       = r_seq;
        n_length    = r_length;
        n_left      = r_left;
        n_reply_cnt = r_reply_cnt;
        n_closed    = r_closed;
        o_res_valid = 1'b0;
        o_res.kind  = KIND_BODY;
        o_res.data_byte = 8'd0;
        o_res.has_data  = 1'b0;
        o_res.action    = ACT_NONE;

        if (i_fire && !r_closed) begin
            if (r_in_body) begin
                n_left          = r_left - 1'b1;
                o_res_valid     = 1'b1;
                o_res.data_byte = i_byte;
                o_res.has_data  = 1'b1;
                if (n_left == '0) begin
                    n_in_body    = 1'b0;
                    o_res.kind   = KIND_DONE;
                    o_res.action = dec_action;
                    n_reply_cnt  = dec_cnt;
                    n_closed     = dec_close;
                end
            end else begin
                if (r_hdr_idx < 4'd2) begin
                    n_magic_acc = {r_magic_acc[7:0], i_byte};
                end else if (r_hdr_idx < 4'd4) begin
                    n_command = {r_command[7:0], i_byte};
                end else if (r_hdr_idx < 4'd6) begin
                    n_command = r_command;
                end else if (r_hdr_idx < 4'd8) begin
                    n_seq = {r_seq[7:0], i_byte};
                end else begin
                    n_length = {r_length[23:0], i_byte};
                end

                if (r_hdr_idx != HDR_LAST) begin
                    n_hdr_idx = r_hdr_idx + 1'b1;
                end else begin
                    n_hdr_idx = '0;
                    if (n_magic_acc != r_magic_word) begin
                        n_closed     = 1'b1;
                        o_res_valid  = 1'b1;
                        o_res.kind   = KIND_BAD_MAGIC;
                        o_res.action = ACT_CLOSE;
                    end else if (n_length > {19'd0, r_max_body_len}) begin
                        n_closed     = 1'b1;
                        o_res_valid  = 1'b1;
                        o_res.kind   = KIND_TOO_LONG;
                        o_res.action = ACT_CLOSE;
                    end else if (n_length == 32'd0) begin
                        o_res_valid  = 1'b1;
                        o_res.kind   = KIND_DONE;
                        o_res.action = dec_action;
                        n_reply_cnt  = dec_cnt;
                        n_closed     = dec_close;
                    end else begin
                        n_in_body = 1'b1;
                        n_left    = n_length[BODY_LEN_W-1:0];
                    end
                end
            end
        end

        o_res.command     = n_command;
        o_res.frame_seq   = n_seq;
        o_res.body_length = n_length;
        o_res.reply_seq   = n_reply_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_word   <= MAGIC_RESET;
            r_max_body_len <= MAX_LEN_RESET;
            r_hdr_idx      <= '0;
            r_in_body      <= 1'b0;
            r_magic_acc    <= '0;
            r_command      <= '0;
            r_seq          <= '0;
            r_length       <= '0;
            r_left         <= '0;
            r_reply_cnt    <= '0;
            r_closed       <= 1'b0;
        end else begin
            r_hdr_idx   <= n_hdr_idx;
            r_in_body   <= n_in_body;
            r_magic_acc <= n_magic_acc;
            r_command   <= n_command;
            r_seq       <= n_seq;
            r_length    <= n_length;
            r_left      <= n_left;
            r_reply_cnt <= n_reply_cnt;
            r_closed    <= n_closed;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_MAGIC_WORD:   r_magic_word   <= i_cfg_wdata;
                    CFG_MAX_BODY_LEN: r_max_body_len <= i_cfg_wdata[BODY_LEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

[hdl/lpfr_out_reg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lpfr_out_reg
// result register toward the master side
// ---------------------------------------------------------------------------
module lpfr_out_reg import lpfr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_res,
    input  logic    i_out_ready
);

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    assign o_ready = !r_valid || i_out_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

[hdl/length_prefixed_frame_receiver_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// length_prefixed_frame_receiver_unit
// deframer for magic- and length-prefixed frames with reply decision
// ---------------------------------------------------------------------------
// Takes one byte per beat and can accept a beat every clock cycle while the
// result register is free or being drained by the master side. A byte is
// held in the input register, parsed by single-pass logic and loaded into
// the result register. Header bytes give no beat except the twelfth, which may
// give an error or an empty-body completion. After a bad magic, an oversized
// body or a BYE the unit drops all bytes until reset. Configuration writes
// are taken at once and must be made while no frame is in flight.
module length_prefixed_frame_receiver_unit import lpfr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // rx_byte
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // data_byte, has_data, command, frame_seq, body_length, action, reply_seq, pad
    output logic [95:0]           m_axis_tdata,
    output logic [1:0]            m_axis_tuser    // kind
);

    logic       in_valid;
    logic [7:0] in_byte;
    logic       out_ready;
    logic       fire;
    logic       res_valid;
    t_result    res;
    t_result    out_res;

    assign fire = in_valid && out_ready;

    lpfr_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .o_valid (in_valid),
        .o_data  (in_byte),
        .i_take  (fire)
    );

    lpfr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (fire),
        .i_byte      (in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    lpfr_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (res_valid),
        .i_res       (res),
        .o_ready     (out_ready),
        .o_valid     (m_axis_tvalid),
        .o_res       (out_res),
        .i_out_ready (m_axis_tready)
    );

    assign m_axis_tuser = out_res.kind;
    assign m_axis_tdata = {5'd0, out_res.reply_seq, out_res.action, out_res.body_length,
                           out_res.frame_seq, out_res.command, out_res.has_data,
                           out_res.data_byte};

endmodule
